FILE: design/knn_plurality_vote_defines.svh
// Assertion macros for the plurality vote block.
// Used by the top level only; expects aclk and aresetn in scope.
`ifndef KNN_PLURALITY_VOTE_DEFINES_SVH
`define KNN_PLURALITY_VOTE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define KNV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define KNV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/knv_pkg.sv
// Shared types and constants for the plurality vote block.
// No dependencies; imported by every module of the block.
package knv_pkg;

    // Default table depth (votes per query)
    localparam int MAX_VOTES_DEF = 16;

    // Label width and the "no winner" label
    localparam int LABEL_W = 32;
    localparam logic signed [LABEL_W-1:0] NONE_LABEL = -32'sd1;

    // One vote word as held in the input register
    typedef struct packed {
        logic                      found;
        logic signed [LABEL_W-1:0] label;
        logic                      last;
    } knv_vote_t;

    // Query result
    typedef struct packed {
        logic signed [LABEL_W-1:0] winner;
        logic                      overflow;
    } knv_result_t;

    // Tally status seen by the top level
    typedef struct packed {
        logic idle;   // no vote counted in the current query
    } knv_status_t;

endpackage

FILE: design/knv_in_stage.sv
// Input register stage: captures one vote word from the slave stream.
// Depends on knv_pkg.
module knv_in_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] class_label
    input  logic                  s_tuser,   // [0] neighbor_found
    input  logic                  s_tlast,   // last_vote
    input  logic                  advance,
    output logic                  vote_valid,
    output knv_pkg::knv_vote_t    vote
);
    import knv_pkg::*;

    logic      vld_reg;
    logic      vld_next;
    knv_vote_t vote_reg;

    // Take a new word whenever the held one moves on or the stage is empty
    assign s_tready = !vld_reg || advance;

    always_comb begin
        vld_next = vld_reg;
        if (s_tready) begin
            vld_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            vote_reg.found <= s_tuser;
            vote_reg.label <= s_tdata;
            vote_reg.last  <= s_tlast;
        end
    end

    assign vote_valid = vld_reg;
    assign vote       = vote_reg;

endmodule

FILE: design/knv_tally.sv
// Label tally table with parallel match, count update and winner tracking.
// Depends on knv_pkg.
module knv_tally #(
    parameter int MAX_VOTES = knv_pkg::MAX_VOTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  vote_fire,
    input  knv_pkg::knv_vote_t    vote,
    output knv_pkg::knv_result_t  result,
    output knv_pkg::knv_status_t  status
);
    import knv_pkg::*;

    localparam int CNT_W = $clog2(MAX_VOTES + 1);

    // Table entries and per-query state
    logic [LABEL_W-1:0]        label_reg [MAX_VOTES];
    logic [CNT_W-1:0]          count_reg [MAX_VOTES];
    logic [MAX_VOTES-1:0]      used_reg;
    logic [MAX_VOTES-1:0]      used_next;
    logic [CNT_W-1:0]          seen_reg;
    logic [CNT_W-1:0]          seen_next;
    logic [CNT_W-1:0]          best_reg;
    logic [CNT_W-1:0]          best_next;
    logic signed [LABEL_W-1:0] winner_reg;
    logic signed [LABEL_W-1:0] winner_next;
    logic                      ovf_reg;
    logic                      ovf_next;

    logic                      room;
    logic                      do_tally;
    logic                      hit;
    logic [MAX_VOTES-1:0]      match;
    logic [MAX_VOTES-1:0]      free_first;
    logic [MAX_VOTES-1:0]      wr_sel;
    logic [CNT_W-1:0]          sel_count;
    logic [CNT_W-1:0]          new_count;
    logic                      best_upd;

    // Match the label against every used entry; find the first free entry
    always_comb begin
        logic prev_used;
        prev_used = 1'b1;
        sel_count = '0;
        for (int i = 0; i < MAX_VOTES; i++) begin
            match[i]      = used_reg[i] && (label_reg[i] == vote.label);
            free_first[i] = !used_reg[i] && prev_used;
            prev_used     = used_reg[i];
            sel_count     = sel_count | (match[i] ? count_reg[i] : '0);
        end
    end

    // Vote accounting: dropped once the query is full
    assign room      = (seen_reg < CNT_W'(MAX_VOTES));
    assign do_tally  = room && vote.found;
    assign hit       = |match;
    assign wr_sel    = hit ? match : free_first;
    assign new_count = (hit ? sel_count : '0) + CNT_W'(1);
    assign best_upd  = do_tally && (new_count > best_reg);

    always_comb begin
        seen_next   = room ? seen_reg + CNT_W'(1) : seen_reg;
        best_next   = best_upd ? new_count : best_reg;
        winner_next = best_upd ? vote.label : winner_reg;
        ovf_next    = ovf_reg || !room;
        used_next   = do_tally ? (used_reg | wr_sel) : used_reg;
    end

    // Result reflects this vote; used only on the last vote of a query
    assign result.winner   = winner_next;
    assign result.overflow = ovf_next;
    assign status.idle     = (seen_reg == '0);

    // Control state: update per vote, clear after the last one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            seen_reg   <= '0;
            best_reg   <= '0;
            winner_reg <= NONE_LABEL;
            ovf_reg    <= 1'b0;
        end else if (vote_fire) begin
            if (vote.last) begin
                used_reg   <= '0;
                seen_reg   <= '0;
                best_reg   <= '0;
                winner_reg <= NONE_LABEL;
                ovf_reg    <= 1'b0;
            end else begin
                used_reg   <= used_next;
                seen_reg   <= seen_next;
                best_reg   <= best_next;
                winner_reg <= winner_next;
                ovf_reg    <= ovf_next;
            end
        end
    end

    // Entry payload; unused entries are masked by used_reg
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_VOTES; i++) begin
            if (vote_fire && do_tally && wr_sel[i]) begin
                label_reg[i] <= vote.label;
                count_reg[i] <= new_count;
            end
        end
    end

endmodule

FILE: design/knn_plurality_vote.sv
// k-nearest-neighbor plurality vote. Each input word carries one neighbor vote
// (class label on tdata, found flag on tuser, end of query on tlast); on the
// last vote of a query one result word gives the label with the most votes
// (first to reach the count wins ties; -1 if no vote was found) and an
// overflow flag set when the query held more than MAX_VOTES votes. One vote is
// taken every clock cycle; output stalls back up only through last votes.
// A result word is loaded into the output register when its last vote leaves
// the input register. The rate is set by the tally update, which compares the
// label against all MAX_VOTES entries and updates count and winner together.
module knn_plurality_vote #(
    parameter int MAX_VOTES = knv_pkg::MAX_VOTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] class_label
    input  logic        s_tuser,   // [0] neighbor_found
    input  logic        s_tlast,   // last_vote
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] winner_label
    output logic        m_tuser    // [0] vote_overflow
);
    import knv_pkg::*;

    `include "knn_plurality_vote_defines.svh"

    logic        vote_valid;
    knv_vote_t   vote;
    knv_result_t result;
    knv_status_t status;
    logic        out_free;
    logic        advance;
    logic        load_out;

    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg;

    // Input register
    knv_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .vote_valid (vote_valid),
        .vote       (vote)
    );

    // Tally table
    knv_tally #(
        .MAX_VOTES (MAX_VOTES)
    ) u_tally (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .vote_fire (advance),
        .vote      (vote),
        .result    (result),
        .status    (status)
    );

    // A vote moves on unless it is a last vote facing a full output register
    assign out_free = !m_tvalid_reg || m_tready;
    assign advance  = vote_valid && (!vote.last || out_free);
    assign load_out = advance && vote.last;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= result.winner;
            m_tuser_reg <= result.overflow;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    `KNV_ASSERT_NEXT(a_clear_after_last, advance && vote.last, status.idle, "tally not cleared after last vote")
    `KNV_ASSERT_NOW(a_result_from_last, $rose(m_tvalid), $past(load_out), "result word without a last vote")
    `KNV_ASSERT_NEXT(a_vote_held, vote_valid && !advance, vote_valid && $stable(vote), "stalled vote lost")

endmodule

FILE: bench/tb.sv
// Testbench for knn_plurality_vote: streams neighbor vote words per query,
// mirrors the tally to predict each elected label and checks every result word.
// Depends on knv_pkg and the design sources of knn_plurality_vote.
module tb;
    import knv_pkg::*;

    localparam int VOTE_DEPTH   = MAX_VOTES_DEF;
    localparam int RANDOM_VOTES = 1800;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 500000;

    // receiver stall patterns
    typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_pattern_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // [31:0] class_label
    logic        s_tuser  = 1'b0;  // [0] neighbor_found
    logic        s_tlast  = 1'b0;  // last_vote
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [31:0] winner_label
    logic        m_tuser;          // [0] vote_overflow

    knn_plurality_vote uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    knv_vote_t   pending_votes[$];
    knv_result_t expected_winners[$];
    int          errors       = 0;
    int          results_seen = 0;
    int          cycles       = 0;

    // Mirror of the per-query tally
    logic signed [LABEL_W-1:0] tbl_label [VOTE_DEPTH];
    logic [4:0]                tbl_count [VOTE_DEPTH];
    int                        n_labels;
    int                        n_votes;
    logic [4:0]                best_votes;
    logic signed [LABEL_W-1:0] leader;
    logic                      overflowed;

    task automatic clear_tally();
        for (int i = 0; i < VOTE_DEPTH; i++) begin
            tbl_label[i] = '0;
            tbl_count[i] = '0;
        end
        n_labels   = 0;
        n_votes    = 0;
        best_votes = '0;
        leader     = NONE_LABEL;
        overflowed = 1'b0;
    endtask

    // Apply one accepted vote; a last vote closes the query and queues its winner
    task automatic count_vote(input knv_vote_t v);
        int          slot;
        knv_result_t r;
        if (n_votes >= VOTE_DEPTH) begin
            overflowed = 1'b1;
        end else begin
            n_votes++;
            if (v.found) begin
                slot = n_labels;
                for (int i = 0; i < n_labels; i++) begin
                    if (slot == n_labels && tbl_label[i] == v.label) slot = i;
                end
                if (slot < VOTE_DEPTH) begin
                    if (slot == n_labels) begin
                        tbl_label[slot] = v.label;
                        tbl_count[slot] = '0;
                        n_labels++;
                    end
                    tbl_count[slot] = tbl_count[slot] + 5'd1;
                    // strictly greater: first label to reach a count keeps the lead
                    if (tbl_count[slot] > best_votes) begin
                        best_votes = tbl_count[slot];
                        leader     = v.label;
                    end
                end
            end
        end
        if (v.last) begin
            r.winner   = leader;
            r.overflow = overflowed;
            expected_winners = {expected_winners, r};
            clear_tally();
        end
    endtask

    task automatic push_vote(input logic f, input logic signed [LABEL_W-1:0] lbl,
                             input logic l);
        knv_vote_t v;
        v.found = f;
        v.label = lbl;
        v.last  = l;
        pending_votes = {pending_votes, v};
    endtask

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Stimulus, reset and end of run
    initial begin
        int                        total;
        int                        qlen;
        int                        pick;
        int                        miss;
        logic signed [LABEL_W-1:0] lbl;
        logic signed [LABEL_W-1:0] pool [4];

        // largest label alone
        push_vote(1'b1, 32'sh7FFF_FFFF, 1'b1);
        // query with nothing found
        push_vote(1'b0, 32'sh1234_5678, 1'b1);
        // tie at two votes: 5 reaches it first, smallest label never retakes
        push_vote(1'b1, 32'sh8000_0000, 1'b0);
        push_vote(1'b1, 32'sd5, 1'b0);
        push_vote(1'b1, 32'sd5, 1'b0);
        push_vote(1'b1, 32'sh8000_0000, 1'b0);
        push_vote(1'b1, 32'sd3, 1'b1);
        // found label of -1 is tallied like any other
        push_vote(1'b1, NONE_LABEL, 1'b1);
        // sixteen distinct labels fill the table, the extra vote overflows
        for (int i = 0; i < VOTE_DEPTH; i++) push_vote(1'b1, 32'sd1000 + i, 1'b0);
        push_vote(1'b1, 32'sd77, 1'b1);

        // random queries: mostly short, some exactly full, some overflowing
        total = 0;
        while (total < RANDOM_VOTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                qlen = $urandom_range(VOTE_DEPTH + 1, VOTE_DEPTH + 8);
            else if (pick < 20)
                qlen = VOTE_DEPTH;
            else
                qlen = $urandom_range(1, 12);
            // small label pool per query so counts build up and tie
            for (int p = 0; p < 4; p++) begin
                case ($urandom_range(0, 3))
                    0: pool[p] = $urandom;
                    1: pool[p] = $urandom_range(0, 7);
                    2: pool[p] = NONE_LABEL;
                    default: pool[p] = 32'h8000_0000 ^ $urandom_range(0, 3);
                endcase
            end
            miss = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
            for (int v = 0; v < qlen; v++) begin
                lbl = ($urandom_range(0, 9) < 8) ? pool[$urandom_range(0, 3)] : $urandom;
                push_vote($urandom_range(0, 15) >= miss, lbl, v == qlen - 1);
            end
            total += qlen;
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_votes.size() > 0 || expected_winners.size() > 0) @(posedge aclk);
        // leave room for any stray word
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Sender: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        knv_vote_t nxt;
        logic      offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_tally();
            burst_left = 0;
            gap_left   = 0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                nxt = pending_votes.pop_front();
                count_vote(nxt);
                offer = 1'b0;
                if (burst_left > 0) burst_left--;
            end
            if (!offer) begin
                if (burst_left == 0 && gap_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(10, 20);
                        default: gap_left = $urandom_range(1, 4);
                    endcase
                end
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_votes.size() > 0) begin
                    nxt   = pending_votes[0];
                    offer = 1'b1;
                    s_tdata <= nxt.label;
                    s_tuser <= nxt.found;
                    s_tlast <= nxt.last;
                end
            end
            s_tvalid <= offer;
        end
    end

    // Receiver: checks each result word, stalls on its own pattern
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          mode_left = 0;
    rx_pattern_t rx_mode   = RX_OPEN;

    always @(posedge aclk) begin
        knv_result_t want;
        logic        rdy;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_winners.size() == 0) begin
                    errors++;
                    $error("unexpected result word: winner_label %0d vote_overflow %0b",
                           $signed(m_tdata), m_tuser);
                end else begin
                    want = expected_winners.pop_front();
                    if (m_tdata !== want.winner) begin
                        errors++;
                        $error("winner_label expected %0d actual %0d",
                               $signed(want.winner), $signed(m_tdata));
                    end
                    if (m_tuser !== want.overflow) begin
                        errors++;
                        $error("vote_overflow expected %0b actual %0b", want.overflow, m_tuser);
                    end
                end
            end
            // one long hold-off mid-run so last votes back up into the input
            if (!hold_done && results_seen >= 40) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                rx_mode   = rx_pattern_t'($urandom_range(0, 2));
                mode_left = $urandom_range(10, 80);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN:   rdy = 1'b1;
                    RX_RANDOM: rdy = 1'($urandom_range(0, 1));
                    default:   rdy = ($urandom_range(0, 3) == 0);
                endcase
            end
            m_tready <= rdy;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

endmodule
